/* hdl/hmhe_pkg.sv */
// Package with the shared types and constants of the HTTP method and host extractor.
package hmhe_pkg;

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 3;
    localparam int LEN_OUT_W = 12;
    localparam int POS_W     = 6;
    localparam int NUM_VERBS = 4;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CH_O     = 8'h6F;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h74;

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_SEARCH = 3'd1,
        PH_GOT_H  = 3'd2,
        PH_GOT_O  = 3'd3,
        PH_GOT_S  = 3'd4,
        PH_GOT_T  = 3'd5,
        PH_HOST   = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    typedef enum logic [CODE_W-1:0] {
        MC_UNKNOWN = 3'd0,
        MC_CONNECT = 3'd1,
        MC_GET     = 3'd2,
        MC_POST    = 3'd3,
        MC_HEAD    = 3'd4
    } t_method_code;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              end_of_request;
    } t_item;

    typedef struct packed {
        logic                 host_byte_valid;
        logic [BYTE_W-1:0]    host_byte;
        logic                 summary_valid;
        t_method_code         method_code;
        logic [LEN_OUT_W-1:0] host_length;
        logic                 host_overflow;
        logic                 host_found;
    } t_result;

endpackage

/* hdl/hmhe_req_if.sv */
// Request channel interface: one request byte with its end flag per transfer.
interface hmhe_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_request;

    modport source (output valid, output byte_in, output end_of_request, input ready);
    modport sink (input valid, input byte_in, input end_of_request, output ready);
endinterface

/* hdl/hmhe_res_if.sv */
// Result channel interface: a host byte and/or the request summary per transfer.
interface hmhe_res_if;
    logic        valid;
    logic        ready;
    logic        host_byte_valid;
    logic [7:0]  host_byte;
    logic        summary_valid;
    logic [2:0]  method_code;
    logic [11:0] host_length;
    logic        host_overflow;
    logic        host_found;

    modport source (
        output valid, output host_byte_valid, output host_byte, output summary_valid,
        output method_code, output host_length, output host_overflow, output host_found,
        input ready
    );
    modport sink (
        input valid, input host_byte_valid, input host_byte, input summary_valid,
        input method_code, input host_length, input host_overflow, input host_found,
        output ready
    );
endinterface

/* hdl/hmhe_core.sv */
// Parser state machine that matches the method, finds the Host header and counts host bytes.
module hmhe_core #(
    parameter int HOST_LEN_MAX   = 4095,
    parameter int METHOD_LEN_MAX = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  hmhe_pkg::t_item   i_item,
    output hmhe_pkg::t_result o_result,
    output logic             o_has_result
);
    import hmhe_pkg::*;

    localparam int CNT_W = $clog2(HOST_LEN_MAX + 1);

    t_phase                r_phase, n_phase;
    logic [NUM_VERBS-1:0]  r_cand, n_cand;
    logic [POS_W-1:0]      r_pos, n_pos;
    t_method_code          r_code, n_code;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_ovf, n_ovf;
    logic                  r_seen, n_seen;
    logic                  emit;

    function automatic logic [BYTE_W-1:0] verb_char(input int unsigned k,
                                                    input logic [2:0] idx);
        logic [7*BYTE_W-1:0] txt;
        case (k)
            0:       txt = "CONNECT";
            1:       txt = {"GET", 32'h0};
            2:       txt = {"POST", 24'h0};
            default: txt = {"HEAD", 24'h0};
        endcase
        if (idx > 3'd6) begin
            return '0;
        end
        return txt[(6 - idx) * BYTE_W +: BYTE_W];
    endfunction

    function automatic logic [POS_W-1:0] verb_len(input int unsigned k);
        case (k)
            0:       return POS_W'(7);
            1:       return POS_W'(3);
            default: return POS_W'(4);
        endcase
    endfunction

    function automatic t_method_code resolve(input logic [NUM_VERBS-1:0] cand,
                                             input logic [POS_W-1:0] pos);
        if (cand[0] && pos == verb_len(0)) begin
            return MC_CONNECT;
        end else if (cand[1] && pos == verb_len(1)) begin
            return MC_GET;
        end else if (cand[2] && pos == verb_len(2)) begin
            return MC_POST;
        end else if (cand[3] && pos == verb_len(3)) begin
            return MC_HEAD;
        end
        return MC_UNKNOWN;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_cand  = r_cand;
        n_pos   = r_pos;
        n_code  = r_code;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_seen  = r_seen;
        case (r_phase)
            PH_METHOD: begin
                if (i_item.byte_in == CH_SPACE) begin
                    n_code  = resolve(r_cand, r_pos);
                    n_phase = PH_SEARCH;
                end else if (r_pos >= POS_W'(METHOD_LEN_MAX)) begin
                    n_cand = '0;
                end else begin
                    for (int unsigned k = 0; k < NUM_VERBS; k++) begin
                        if (r_pos >= verb_len(k) || verb_char(k, r_pos[2:0]) != i_item.byte_in) begin
                            n_cand[k] = 1'b0;
                        end
                    end
                    n_pos = r_pos + POS_W'(1);
                end
            end
            PH_SEARCH: begin
                if (i_item.byte_in == CH_H) begin
                    n_phase = PH_GOT_H;
                end
            end
            PH_GOT_H: n_phase = (i_item.byte_in == CH_O) ? PH_GOT_O : PH_SEARCH;
            PH_GOT_O: n_phase = (i_item.byte_in == CH_S) ? PH_GOT_S : PH_SEARCH;
            PH_GOT_S: n_phase = (i_item.byte_in == CH_T) ? PH_GOT_T : PH_SEARCH;
            PH_GOT_T: begin
                if (i_item.byte_in == CH_COLON) begin
                    n_phase = PH_HOST;
                    n_seen  = 1'b1;
                end else begin
                    n_phase = PH_SEARCH;
                end
            end
            PH_HOST: begin
                if (i_item.byte_in == CH_CR || i_item.byte_in == CH_COLON) begin
                    n_phase = PH_DONE;
                end else if (emit) begin
                    if (r_count >= CNT_W'(HOST_LEN_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            default: n_phase = r_phase;
        endcase
    end

    always_comb begin
        emit = (r_phase == PH_HOST) && (i_item.byte_in != CH_CR)
            && (i_item.byte_in != CH_COLON) && (i_item.byte_in != CH_SPACE);
        o_has_result             = emit || i_item.end_of_request;
        o_result                 = '0;
        o_result.host_byte_valid = emit;
        o_result.host_byte       = emit ? i_item.byte_in : '0;
        if (i_item.end_of_request) begin
            o_result.summary_valid = 1'b1;
            o_result.method_code   = (n_phase == PH_METHOD) ? resolve(n_cand, n_pos) : n_code;
            o_result.host_length   = LEN_OUT_W'(n_count);
            o_result.host_overflow = n_ovf;
            o_result.host_found    = n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.end_of_request)) begin
            r_phase <= PH_METHOD;
            r_cand  <= '1;
            r_pos   <= '0;
            r_code  <= MC_UNKNOWN;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_seen  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cand  <= n_cand;
            r_pos   <= n_pos;
            r_code  <= n_code;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_seen  <= n_seen;
        end
    end

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.end_of_request |=> r_phase == PH_METHOD && r_pos == '0 && !r_seen)
        else $error("State was not cleared after the last byte of a request.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HOST_LEN_MAX))
        else $error("Host byte count went past its maximum.");

    a_ovf_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CNT_W'(HOST_LEN_MAX))
        else $error("Overflow flag set while the count is below its maximum.");

    a_host_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HOST || r_phase == PH_DONE) |-> r_seen)
        else $error("Host phase reached without the Host header flag.");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(METHOD_LEN_MAX))
        else $error("Method position went past its limit.");

endmodule

/* hdl/http_method_and_host_extractor_top.sv */
// Top level of the HTTP method and host extractor with its input and result registers.
//
//   Channel  Modport  Transfer carries
//   i_req    sink     one request byte and its end-of-request flag
//   o_res    source   a host byte, the request summary, or both
//
// Each byte passes combinationally through the parser, from the input register to the result register.
// One byte can be taken every cycle while the result side keeps up.
// A byte that yields no result passes even while a result waits to be taken.
// Reset is synchronous and active low; the parser returns to the method phase after
// reset and after every byte that ends a request.
module http_method_and_host_extractor_top #(
    parameter int HOST_LEN_MAX   = 4095,
    parameter int METHOD_LEN_MAX = 49
) (
    input logic     i_clk,
    input logic     i_rst_n,
    hmhe_req_if.sink   i_req,
    hmhe_res_if.source o_res
);
    import hmhe_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    core_has_result;
    logic    core_step;

    assign core_step   = r_in_valid && (!core_has_result || !r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || core_step;

    hmhe_core #(
        .HOST_LEN_MAX  (HOST_LEN_MAX),
        .METHOD_LEN_MAX(METHOD_LEN_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (core_step),
        .i_item      (r_in),
        .o_result    (core_result),
        .o_has_result(core_has_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.byte_in        <= i_req.byte_in;
            r_in.end_of_request <= i_req.end_of_request;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_step && core_has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_step && core_has_result) begin
            r_out <= core_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.host_byte_valid = r_out.host_byte_valid;
    assign o_res.host_byte       = r_out.host_byte;
    assign o_res.summary_valid   = r_out.summary_valid;
    assign o_res.method_code     = r_out.method_code;
    assign o_res.host_length     = r_out.host_length;
    assign o_res.host_overflow   = r_out.host_overflow;
    assign o_res.host_found      = r_out.host_found;

    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.host_byte_valid || r_out.summary_valid))
        else $error("A result transfer carries neither a host byte nor a summary.");

    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_step && core_has_result |-> !r_out_valid || o_res.ready)
        else $error("A result was produced while the result register was full.");

    a_held_byte_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !core_step |=> r_in_valid && $stable(r_in))
        else $error("A pending request byte was lost or changed before it was parsed.");

endmodule
